@@ rtl/ppri_pkg.sv @@
// ----------------------------------------------------------------------------
// ppri_pkg
// Shared types, constants and tables for the planar pose rollout integrator.
// ----------------------------------------------------------------------------
`default_nettype none

package ppri_pkg;

  localparam int CORDIC_ITERATIONS = 16;
  localparam int ATAN_ENTRIES      = 24;
  localparam int NUM_ITER          = (CORDIC_ITERATIONS < ATAN_ENTRIES) ?
                                     CORDIC_ITERATIONS : ATAN_ENTRIES;
  localparam int ITER_W            = (NUM_ITER > 1) ? $clog2(NUM_ITER) : 1;

  // heading range reduction: remainder by 2*pi through a reciprocal multiply,
  // a subtract and one correcting compare/subtract
  localparam logic [31:0] TWO_PI_U     = 32'd411775;
  localparam logic [13:0] TWO_PI_RECIP = 14'd10430;  // floor(2^32 / TWO_PI_U)

  localparam logic signed [20:0] TWO_PI_Q16  = 21'sd411775;
  localparam logic signed [20:0] PI_Q16      = 21'sd205887;
  localparam logic signed [20:0] HALF_PI_Q16 = 21'sd102944;

  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

  localparam logic [15:0] STEP_TIME_RESET = 16'd3277;

  typedef enum logic [0:0] {
    CFG_STEP_TIME = 1'b0,
    CFG_HOLONOMIC = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic               done;
    logic signed [31:0] cos_v;
    logic signed [31:0] sin_v;
  } trig_t;

  function automatic logic [31:0] atan_q30(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'd843314857;
      5'd1:    v = 32'd497837829;
      5'd2:    v = 32'd263043837;
      5'd3:    v = 32'd133525159;
      5'd4:    v = 32'd67021687;
      5'd5:    v = 32'd33543516;
      5'd6:    v = 32'd16775851;
      5'd7:    v = 32'd8388437;
      5'd8:    v = 32'd4194283;
      5'd9:    v = 32'd2097149;
      5'd10:   v = 32'd1048576;
      5'd11:   v = 32'd524288;
      5'd12:   v = 32'd262144;
      5'd13:   v = 32'd131072;
      5'd14:   v = 32'd65536;
      5'd15:   v = 32'd32768;
      5'd16:   v = 32'd16384;
      5'd17:   v = 32'd8192;
      5'd18:   v = 32'd4096;
      5'd19:   v = 32'd2048;
      5'd20:   v = 32'd1024;
      5'd21:   v = 32'd512;
      5'd22:   v = 32'd256;
      5'd23:   v = 32'd128;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

@@ rtl/ppri_sincos.sv @@
// ----------------------------------------------------------------------------
// ppri_sincos
// Iterative heading reduction and rotation-mode CORDIC giving cos and sin.
// ----------------------------------------------------------------------------
`default_nettype none

module ppri_sincos (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [31:0]  heading_i,
  output ppri_pkg::trig_t     trig_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_QUOT,
    S_REDUCE,
    S_FIX,
    S_FOLD,
    S_ROT,
    S_DONE
  } state_e;

  state_e                         state_q, state_d;
  logic [12:0]                    q_q, q_d;
  logic [31:0]                    rem_q, rem_d;
  logic                           hneg_q, hneg_d;
  logic                           fneg_q, fneg_d;
  logic signed [33:0]             x_q, x_d, y_q, y_d, z_q, z_d;
  logic [ppri_pkg::ITER_W-1:0]    i_q, i_d;

  logic [45:0]        qprod;
  logic [31:0]        qmul;
  logic [32:0]        habs;
  logic signed [20:0] r0, r1, r2;
  logic               fneg;
  logic signed [33:0] xs, ys, at;
  logic signed [33:0] xo, yo;

  assign habs = heading_i[31] ? (33'd0 - {heading_i[31], heading_i})
                              : {1'b0, heading_i};
  // quotient estimate is exact or one low; the correction cycle fixes it
  assign qprod = rem_q * ppri_pkg::TWO_PI_RECIP;
  assign qmul  = {19'd0, q_q} * ppri_pkg::TWO_PI_U;

  always_comb begin
    r0 = hneg_q ? (21'sd0 - $signed({2'b00, rem_q[18:0]}))
                : $signed({2'b00, rem_q[18:0]});
    r1 = r0;
    if (r0 > ppri_pkg::PI_Q16) begin
      r1 = r0 - ppri_pkg::TWO_PI_Q16;
    end else if (r0 < -ppri_pkg::PI_Q16) begin
      r1 = r0 + ppri_pkg::TWO_PI_Q16;
    end
    r2   = r1;
    fneg = 1'b0;
    if (r1 > ppri_pkg::HALF_PI_Q16) begin
      r2   = r1 - ppri_pkg::PI_Q16;
      fneg = 1'b1;
    end else if (r1 < -ppri_pkg::HALF_PI_Q16) begin
      r2   = r1 + ppri_pkg::PI_Q16;
      fneg = 1'b1;
    end
  end

  assign xs = x_q >>> i_q;
  assign ys = y_q >>> i_q;
  assign at = $signed({2'b00, ppri_pkg::atan_q30(5'(i_q))});

  always_comb begin
    state_d = state_q;
    q_d     = q_q;
    rem_d   = rem_q;
    hneg_d  = hneg_q;
    fneg_d  = fneg_q;
    x_d     = x_q;
    y_d     = y_q;
    z_d     = z_q;
    i_d     = i_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          rem_d   = habs[31:0];
          hneg_d  = heading_i[31];
          state_d = S_QUOT;
        end
      end
      S_QUOT: begin
        q_d     = qprod[44:32];
        state_d = S_REDUCE;
      end
      S_REDUCE: begin
        rem_d   = rem_q - qmul;
        state_d = S_FIX;
      end
      S_FIX: begin
        if (rem_q >= ppri_pkg::TWO_PI_U) begin
          rem_d = rem_q - ppri_pkg::TWO_PI_U;
        end
        state_d = S_FOLD;
      end
      S_FOLD: begin
        fneg_d  = fneg;
        x_d     = ppri_pkg::CORDIC_GAIN_Q30;
        y_d     = '0;
        z_d     = $signed({{13{r2[20]}}, r2}) <<< 14;
        i_d     = '0;
        state_d = S_ROT;
      end
      S_ROT: begin
        if (!z_q[33]) begin
          x_d = x_q - ys;
          y_d = y_q + xs;
          z_d = z_q - at;
        end else begin
          x_d = x_q + ys;
          y_d = y_q - xs;
          z_d = z_q + at;
        end
        i_d = i_q + 1'b1;
        if (i_q == ppri_pkg::ITER_W'(ppri_pkg::NUM_ITER - 1)) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      q_q     <= '0;
      rem_q   <= '0;
      hneg_q  <= 1'b0;
      fneg_q  <= 1'b0;
      x_q     <= '0;
      y_q     <= '0;
      z_q     <= '0;
      i_q     <= '0;
    end else begin
      state_q <= state_d;
      q_q     <= q_d;
      rem_q   <= rem_d;
      hneg_q  <= hneg_d;
      fneg_q  <= fneg_d;
      x_q     <= x_d;
      y_q     <= y_d;
      z_q     <= z_d;
      i_q     <= i_d;
    end
  end

  assign xo = fneg_q ? (34'sd0 - x_q) : x_q;
  assign yo = fneg_q ? (34'sd0 - y_q) : y_q;

  assign trig_o.done  = (state_q == S_DONE);
  assign trig_o.cos_v = xo[31:0];
  assign trig_o.sin_v = yo[31:0];

endmodule

`default_nettype wire

@@ rtl/planar_pose_rollout_integrator.sv @@
// ----------------------------------------------------------------------------
// planar_pose_rollout_integrator
// Advances a planar pose one fixed-point unicycle/holonomic step per transaction.
// ----------------------------------------------------------------------------
//   channel   direction  handshake              payload
//   in        sink       in_valid_i/in_ready_o  first_step, start pose, velocities
//   out       source     out_valid_o/out_ready_i pos_x, pos_y, heading
//   cfg       sink       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// A transaction runs the remainder by 2*pi (quotient estimate, subtract,
// correction), a fold, one CORDIC iteration per cycle, the cos/sin hand-over,
// the products on the shared 32x17 multiplier, the output register and an
// idle state with in_ready_o high.
// A result held by out_ready_i low stalls the next transaction at the output.
// Reset clears the pose to zero, step time to 3277, holonomic mode off.
// ----------------------------------------------------------------------------
`default_nettype none

module planar_pose_rollout_integrator (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               first_step_i,
  input  logic signed [31:0] start_x_i,
  input  logic signed [31:0] start_y_i,
  input  logic signed [31:0] start_heading_i,
  input  logic signed [15:0] vel_forward_i,
  input  logic signed [15:0] vel_lateral_i,
  input  logic signed [15:0] vel_turn_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] heading_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [0:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_TRIG,
    S_MUL,
    S_EMIT
  } state_e;

  state_e             state_q;
  logic [2:0]         m_q;
  logic [15:0]        step_time_q;
  logic               holo_q;
  logic signed [31:0] acc_x_q, acc_y_q, acc_h_q;
  logic signed [15:0] vf_q, vl_q, vt_q;
  logic signed [31:0] c_q, s_q;
  logic signed [48:0] prod_q;
  logic signed [49:0] dx_q, dy_q;
  logic               out_valid_q;
  logic signed [31:0] out_x_q, out_y_q, out_h_q;

  logic               in_acc;
  logic signed [31:0] trig_heading;
  ppri_pkg::trig_t    trig;
  logic signed [31:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [16:0] dt_s;
  logic signed [49:0] prod_x;

  function automatic logic signed [31:0] rnd26(input logic signed [49:0] v);
    logic signed [49:0] t;
    t = (v + (50'sd1 <<< 25)) >>> 26;
    return t[31:0];
  endfunction

  function automatic logic signed [33:0] rnd_sh(input logic signed [49:0] v,
                                                input logic [4:0] sh);
    logic signed [49:0] t;
    t = (v + (50'sd1 <<< (sh - 5'd1))) >>> sh;
    return t[33:0];
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [33:0] d);
    logic signed [34:0] r;
    logic signed [31:0] o;
    r = $signed({{3{a[31]}}, a}) + $signed({d[33], d});
    if (r > 35'sd2147483647) begin
      o = 32'sh7fffffff;
    end else if (r < -35'sd2147483648) begin
      o = 32'sh80000000;
    end else begin
      o = r[31:0];
    end
    return o;
  endfunction

  assign in_ready_o   = (state_q == S_IDLE);
  assign in_acc       = in_valid_i && in_ready_o;
  assign cfg_ready_o  = 1'b1;
  assign trig_heading = first_step_i ? start_heading_i : acc_h_q;
  assign dt_s         = $signed({1'b0, step_time_q});
  assign prod_x       = $signed({prod_q[48], prod_q});

  ppri_sincos u_sincos (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (in_acc),
    .heading_i (trig_heading),
    .trig_o    (trig)
  );

  // shared multiplier operand schedule
  always_comb begin
    mul_a = c_q;
    mul_b = $signed({vf_q[15], vf_q});
    case (m_q)
      3'd0: begin
        mul_a = c_q;
        mul_b = $signed({vf_q[15], vf_q});
      end
      3'd1: begin
        mul_a = s_q;
        mul_b = $signed({vf_q[15], vf_q});
      end
      3'd2: begin
        mul_a = s_q;
        mul_b = $signed({vl_q[15], vl_q});
      end
      3'd3: begin
        mul_a = c_q;
        mul_b = $signed({vl_q[15], vl_q});
      end
      3'd4: begin
        mul_a = rnd26(dx_q);
        mul_b = dt_s;
      end
      3'd5: begin
        mul_a = rnd26(dy_q);
        mul_b = dt_s;
      end
      3'd6: begin
        mul_a = $signed({{16{vt_q[15]}}, vt_q});
        mul_b = dt_s;
      end
      default: begin
        mul_a = c_q;
        mul_b = dt_s;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (in_acc) begin
      vf_q <= vel_forward_i;
      vl_q <= vel_lateral_i;
      vt_q <= vel_turn_i;
    end
    if (trig.done) begin
      c_q <= trig.cos_v;
      s_q <= trig.sin_v;
    end
    if (state_q == S_MUL) begin
      case (m_q)
        3'd1: dx_q <= prod_x;
        3'd2: dy_q <= prod_x;
        3'd3: if (holo_q) dx_q <= dx_q - prod_x;
        3'd4: if (holo_q) dy_q <= dy_q + prod_x;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      m_q         <= '0;
      step_time_q <= ppri_pkg::STEP_TIME_RESET;
      holo_q      <= 1'b0;
      acc_x_q     <= '0;
      acc_y_q     <= '0;
      acc_h_q     <= '0;
      out_valid_q <= 1'b0;
      out_x_q     <= '0;
      out_y_q     <= '0;
      out_h_q     <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          ppri_pkg::CFG_STEP_TIME: step_time_q <= cfg_data_i;
          ppri_pkg::CFG_HOLONOMIC: holo_q      <= cfg_data_i[0];
          default: begin
          end
        endcase
      end
      if (out_valid_q && out_ready_i && state_q != S_EMIT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (first_step_i) begin
              acc_x_q <= start_x_i;
              acc_y_q <= start_y_i;
              acc_h_q <= start_heading_i;
            end
            state_q <= S_TRIG;
          end
        end
        S_TRIG: begin
          if (trig.done) begin
            m_q     <= '0;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          m_q <= m_q + 3'd1;
          case (m_q)
            3'd5: acc_x_q <= sat_add(acc_x_q, rnd_sh(prod_x, 5'd16));
            3'd6: acc_y_q <= sat_add(acc_y_q, rnd_sh(prod_x, 5'd16));
            3'd7: begin
              acc_h_q <= sat_add(acc_h_q, rnd_sh(prod_x, 5'd12));
              state_q <= S_EMIT;
            end
            default: begin
            end
          endcase
        end
        S_EMIT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_x_q     <= acc_x_q;
            out_y_q     <= acc_y_q;
            out_h_q     <= acc_h_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign pos_x_o     = out_x_q;
  assign pos_y_o     = out_y_q;
  assign heading_o   = out_h_q;

`ifndef SYNTH
  a_trig_only_when_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    trig.done |-> state_q == S_TRIG)
    else $error("trig result outside of wait state");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("input ready right after a transaction");

  a_trig_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    trig.done |-> (trig.cos_v <= 32'sd1100000000 && trig.cos_v >= -32'sd1100000000
                   && trig.sin_v <= 32'sd1100000000 && trig.sin_v >= -32'sd1100000000))
    else $error("cordic output out of range");

  a_emit_loads_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && (!out_valid_q || out_ready_i)) |=> out_valid_o)
    else $error("result not presented");
`endif

endmodule

`default_nettype wire
